### src/ffq_pkg.sv
`default_nettype none
package ffq_pkg;
	localparam int unsigned MantBits = 23;
	localparam int unsigned SignPos = 31;
	localparam int unsigned MinFrac = 4;
	localparam int unsigned MaxFrac = 16;
	localparam logic [4:0] FracReset = 5'd8;
	localparam logic [7:0] ExpBias = 8'd127;
	localparam logic CmdEncode = 1'b0;
	localparam logic CmdDecode = 1'b1;
endpackage
`default_nettype wire

### src/ffq_convert.sv
`default_nettype none
module ffq_convert import ffq_pkg::*; (
	input  wire logic        cmd,
	input  wire logic [31:0] value_bits,
	input  wire logic [4:0]  m,
	output logic      [31:0] result
);
	logic        sign;
	logic [7:0]  e;
	logic [22:0] mt;
	logic [23:0] s;
	logic [8:0]  sh;
	logic [15:0] f_enc;
	logic [15:0] f_dec;
	logic [15:0] f_max;
	logic [4:0]  p;
	logic [7:0]  ex;
	logic [22:0] mant;
	logic [31:0] enc;
	logic [31:0] dec;
	logic [31:0] maxpat;
	logic        m_ok;

	assign sign = value_bits[SignPos];
	assign e    = value_bits[30:23];
	assign mt   = value_bits[22:0];
	assign m_ok = (m >= 5'(MinFrac)) && (m <= 5'(MaxFrac));
	assign f_max = 16'((17'd1 << m) - 17'd1);

	// saturation pattern: exponent 126, mantissa of all-ones fraction
	always_comb begin
		maxpat = {1'b0, 8'(ExpBias - 8'd1), 23'(({7'd0, f_max} << (5'd24 - m)))};
	end

	// encode fraction: truncate significand
	always_comb begin
		s  = {1'b1, mt};
		sh = 9'd150 - {1'b0, e} - {4'd0, m};
		f_enc = (e == 8'd0 || sh >= 9'd24) ? 16'd0 : 16'(s >> sh[4:0]);
	end

	always_comb begin
		if (e == 8'hFF && mt != 23'd0) enc = 32'd0;
		else if (e >= ExpBias) enc = {sign, maxpat[30:0]};
		else if (e == 8'd0 && mt == 23'd0) enc = 32'd0;
		else enc = {sign, 31'(({15'd0, f_enc} << (5'd23 - m)))};
	end

	// decode: leading-one search and normalize
	assign f_dec = 16'((value_bits[22:0] >> (5'd23 - m)) & {7'd0, f_max});
	always_comb begin
		p = 5'd0;
		for (int i = 0; i < 16; i++) begin
			if (f_dec[i]) p = 5'(i);
		end
		ex   = 8'(ExpBias + {3'd0, p} - {3'd0, m});
		mant = 23'(({7'd0, f_dec} << (5'd23 - p)));
		dec  = (f_dec == 16'd0) ? {sign, 31'd0} : {sign, ex, mant};
	end

	always_comb begin
		if (!m_ok) result = 32'd0;
		else if (cmd == CmdEncode) result = enc;
		else result = dec;
	end
endmodule
`default_nettype wire

### src/float_fraction_quantizer_core.sv
`default_nettype none
// Float/fraction quantizer: encode (cmd 0) or decode (cmd 1) one binary32 word.
// Takes one word per cycle; busy is always low. Each result appears on
// result_bits with done high in the cycle after start, and must be
// taken in that cycle: the receiver cannot stall. The result is held in the
// single result register behind the conversion logic.
module float_fraction_quantizer_core import ffq_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        cmd,
	input  wire logic [31:0] value_bits,
	input  wire logic        cfg_we,
	input  wire logic [4:0]  cfg_wdata,
	output logic             done,
	output logic      [31:0] result_bits
);
	logic [4:0]  frac_q;
	logic [31:0] res_c;
	logic        done_q;
	logic [31:0] res_q;

	assign busy = 1'b0;

	// width register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) frac_q <= FracReset;
		else if (cfg_we) frac_q <= cfg_wdata;
	end

	ffq_convert u_conv (
		.cmd(cmd), .value_bits(value_bits), .m(frac_q), .result(res_c)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else done_q <= start;
	end
	always_ff @(posedge clk) begin
		if (start) res_q <= res_c;
	end

	assign done = done_q;
	assign result_bits = res_q;
endmodule
`default_nettype wire

### tb/sv/ffq_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module ffq_checker import ffq_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic        busy,
	input  wire logic        cmd,
	input  wire logic [31:0] value_bits,
	input  wire logic        cfg_we,
	input  wire logic [4:0]  cfg_wdata,
	input  wire logic        done,
	input  wire logic [31:0] result_bits,
	output int               fail_count,
	output int               pending_words,
	output int               result_count
);
	logic [4:0] width_q;
	logic [31:0] expected_words[$];

	// normalized pattern (no sign) of f / 2^m, f nonzero
	function automatic logic [31:0] frac_to_float(logic [31:0] f, logic [4:0] m);
		int p;
		logic [7:0] ex;
		logic [31:0] mant;
		p = 0;
		for (int i = 0; i < 32; i++)
			if (f[i]) p = i;
		ex = 8'(ExpBias + p - m);
		mant = (f << (MantBits - p)) & 32'h7FFFFF;
		return {1'b0, ex, mant[22:0]};
	endfunction

	function automatic logic [31:0] quantize(logic c, logic [31:0] x, logic [4:0] m);
		logic sgn;
		logic [7:0] ex;
		logic [22:0] mt;
		logic [31:0] f, sig;
		int sh;
		sgn = x[31];
		ex = x[30:23];
		mt = x[22:0];
		if (m < MinFrac || m > MaxFrac) return 32'd0;
		if (c == CmdDecode) begin
			f = (x >> (MantBits - m)) & ((32'd1 << m) - 1);
			return {sgn, 31'd0} | ((f == 0) ? 32'd0 : frac_to_float(f, m));
		end
		if (ex == 8'hFF && mt != 0) return 32'd0;
		if (ex >= ExpBias)
			return {sgn, 31'd0} | frac_to_float((32'd1 << m) - 1, m);
		if (ex == 0 && mt == 0) return 32'd0;
		f = 0;
		if (ex != 0) begin
			sig = {9'd1, mt};
			sh = 150 - ex - m;
			f = (sh >= 24) ? 32'd0 : (sig >> sh);
		end
		return {sgn, 31'd0} | (f << (MantBits - m));
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %08h want %08h", what, got, want);
		fail_count++;
	endtask

	assign pending_words = expected_words.size();

	// predict on accepted words, check each done word
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= FracReset;
			fail_count = 0;
			result_count = 0;
			expected_words.delete();
		end else begin
			if (done) begin
				result_count++;
				if (expected_words.size() == 0)
					report_mismatch("unexpected word", result_bits, 32'd0);
				else begin
					logic [31:0] want;
					want = expected_words.pop_front();
					if (result_bits !== want)
						report_mismatch("result_bits", result_bits, want);
				end
			end
			if (start && !busy)
				expected_words.push_back(quantize(cmd, value_bits, width_q));
			if (cfg_we)
				width_q <= cfg_wdata;
		end
	end
endmodule
`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 100ps
`default_nettype none
module testbench import ffq_pkg::*;;
	logic clk = 0, arst_n = 0, start = 0, cmd = 0, cfg_we = 0;
	logic [31:0] value_bits = 0;
	logic [4:0] cfg_wdata = FracReset;
	logic busy, done;
	logic [31:0] result_bits;
	int fail_count, pending_words, result_count;
	int idle_cycles = 0;
	bit quiet_stretch = 0;

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	float_fraction_quantizer_core dut (.*);
	ffq_checker chk (.*);

	// watchdog: cycles with nothing accepted
	always @(posedge clk) begin
		if ((start && !busy) || done || cfg_we) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 2000) begin
			$display("timeout");
			$display("status: fail");
			$finish;
		end
	end

	task automatic send_word(logic c, logic [31:0] v);
		cmd <= c;
		value_bits <= v;
		start <= 1;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	task automatic gap();
		if (!quiet_stretch && $urandom_range(99) < 9) begin
			start <= 0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
	endtask

	task automatic drain();
		start <= 0;
		while (pending_words != 0) @(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic set_width(logic [4:0] w);
		drain();
		cfg_wdata <= w;
		cfg_we <= 1;
		@(negedge clk);
		cfg_we <= 0;
	endtask

	// random value, biased toward the interesting exponent band
	function automatic logic [31:0] rand_value(logic c);
		logic [31:0] v;
		v = $urandom;
		if (c == CmdEncode && $urandom_range(3) != 0)
			v[30:23] = 8'($urandom_range(100, 128));
		return v;
	endfunction

	logic [31:0] directed[] = '{32'h00000000, 32'h80000000, 32'h3F800000, 32'hBF800000,
		32'h7F800000, 32'hFF800000, 32'h7FC00000, 32'hFF800001, 32'h3F7FFFFF,
		32'hBF7FFFFF, 32'h3F000000, 32'hBB000000, 32'h00000001, 32'h807FFFFF,
		32'h3E800001, 32'hFFFFFFFF, 32'h7FFFFFFF};
	logic [4:0] widths[] = '{5'd4, 5'd16, 5'd0, 5'd31, 5'd3, 5'd17, 5'd11, 5'd8};

	initial begin
		repeat (11) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		// directed words at reset width
		foreach (directed[i]) send_word(CmdEncode, directed[i]);
		foreach (directed[i]) if (i < 8) send_word(CmdDecode, directed[i]);
		foreach (widths[w]) begin
			set_width(widths[w]);
			quiet_stretch = (w == 1);
			for (int n = 0; n < 50; n++) begin
				logic c;
				c = 1'($urandom_range(1));
				gap();
				send_word(c, rand_value(c));
			end
		end
		drain();
		$display("covered encode/decode words over %0d results, widths 0..31 incl. 4 and 16",
			result_count);
		if (fail_count == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end
endmodule
`default_nettype wire

### filelist.f
src/ffq_pkg.sv
src/ffq_convert.sv
src/float_fraction_quantizer_core.sv
tb/sv/ffq_checker.sv
tb/sv/testbench.sv
